// File: rtl/core/mssr_pkg.sv
// Shared types and constants for the motor soft-start ramp controller.
// No dependencies; used by mssr_arith and motor_soft_start_ramp_with_timeout.
package mssr_pkg;

  // Fixed field widths
  localparam int LEN_BITS      = 16;  // ramp length, elapsed slice, idle limit
  localparam int FUNC_BITS     = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;  // widest configuration register

  // Parameter defaults
  localparam int DUTY_BITS_DEF = 8;
  localparam int TIME_BITS_DEF = 32;

  // Reset values of the configuration registers
  localparam int RST_START_DUTY = 100;
  localparam int RST_END_DUTY   = 255;
  localparam int RST_RAMP_LEN   = 2000;
  localparam int RST_IDLE_LIMIT = 30;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_START_DUTY = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_END_DUTY   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RAMP_LEN   = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_LIMIT = 2'd3;

  // Command codes
  localparam logic [FUNC_BITS-1:0] FN_START  = 3'd0;
  localparam logic [FUNC_BITS-1:0] FN_UPDATE = 3'd1;
  localparam logic [FUNC_BITS-1:0] FN_STOP   = 3'd2;
  localparam logic [FUNC_BITS-1:0] FN_CANCEL = 3'd3;
  localparam logic [FUNC_BITS-1:0] FN_REARM  = 3'd4;
  localparam logic [FUNC_BITS-1:0] FN_TICK   = 3'd5;

  // Top-level sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_SEND
  } ctrl_state_t;

  // Shared multiply/divide unit phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MUL,
    PH_DIV
  } arith_phase_t;

endpackage

// File: rtl/core/mssr_arith.sv
// Serial multiply-then-divide unit: quot = factor * elapsed / length.
// One shared add/subtract datapath, shift-add then restoring division.
// Depends on mssr_pkg.
module mssr_arith #(
  parameter int DUTY_BITS = mssr_pkg::DUTY_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [DUTY_BITS-1:0]          factor,
  input  logic [mssr_pkg::LEN_BITS-1:0] elapsed,
  input  logic [mssr_pkg::LEN_BITS-1:0] length,
  output logic                          done,
  output logic [DUTY_BITS-1:0]          quot
);

  localparam int LB        = mssr_pkg::LEN_BITS;
  localparam int PROD_BITS = DUTY_BITS + LB;
  localparam int CNT_BITS  = $clog2(PROD_BITS);

  mssr_pkg::arith_phase_t phase;
  logic [CNT_BITS-1:0]  cnt;
  logic [PROD_BITS-1:0] prod;     // product, then dividend/quotient shifter
  logic [LB-1:0]        rem;
  logic [LB-1:0]        mcand;
  logic [LB-1:0]        divisor;

  // shared adder
  logic          sub;
  logic [LB:0]   op_a;
  logic [LB:0]   op_b;
  logic [LB+1:0] sum;
  logic          qbit;

  always_comb begin
    sub = (phase == mssr_pkg::PH_DIV);
    if (sub) begin
      op_a = {rem, prod[PROD_BITS-1]};
      op_b = {1'b0, divisor};
    end else begin
      op_a = {1'b0, prod[PROD_BITS-1:DUTY_BITS]};
      op_b = prod[0] ? {1'b0, mcand} : '0;
    end
    sum  = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)} + (LB+2)'(sub);
    qbit = sum[LB+1];  // no borrow on subtract
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= mssr_pkg::PH_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        mssr_pkg::PH_IDLE: begin
          if (start) begin
            phase <= mssr_pkg::PH_MUL;
            cnt   <= CNT_BITS'(DUTY_BITS - 1);
          end
        end
        mssr_pkg::PH_MUL: begin
          if (cnt == '0) begin
            phase <= mssr_pkg::PH_DIV;
            cnt   <= CNT_BITS'(PROD_BITS - 1);
          end else begin
            cnt <= cnt - CNT_BITS'(1);
          end
        end
        mssr_pkg::PH_DIV: begin
          if (cnt == '0) begin
            phase <= mssr_pkg::PH_IDLE;
            done  <= 1'b1;
          end else begin
            cnt <= cnt - CNT_BITS'(1);
          end
        end
        default: phase <= mssr_pkg::PH_IDLE;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    case (phase)
      mssr_pkg::PH_IDLE: begin
        if (start) begin
          prod    <= PROD_BITS'(factor);
          mcand   <= elapsed;
          divisor <= length;
          rem     <= '0;
        end
      end
      mssr_pkg::PH_MUL: begin
        prod <= {sum[LB:0], prod[DUTY_BITS-1:1]};
      end
      mssr_pkg::PH_DIV: begin
        rem  <= qbit ? sum[LB-1:0] : op_a[LB-1:0];
        prod <= {prod[PROD_BITS-2:0], qbit};
      end
      default: ;
    endcase
  end

  // elapsed < length, so the quotient stays below factor
  assign quot = prod[DUTY_BITS-1:0];

endmodule

// File: rtl/core/motor_soft_start_ramp_with_timeout.sv
// Motor soft-start ramp controller with inactivity watchdog, top level (mssr_pkg, mssr_arith).
// Timing: a plain command's result is registered on acceptance and offered in the next cycle;
//   an interpolating update waits in ST_CALC for the serial multiply and divide in mssr_arith.
// Flow: s_axis_tready is high only while idle, so a new command is taken only after the
//   previous result has been sent and taken; m_axis_tready held low stalls the stream.
// Reset (rst, synchronous): flags, timer and counters clear, config to defaults.
module motor_soft_start_ramp_with_timeout #(
  parameter int DUTY_BITS = mssr_pkg::DUTY_BITS_DEF,  // 4..16
  parameter int TIME_BITS = mssr_pkg::TIME_BITS_DEF   // 16..32
) (
  input  logic clk,
  input  logic rst,

  // command stream
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // [2:0] func, [TIME_BITS+2:3] now_ms, rest zero
  input  logic [((mssr_pkg::FUNC_BITS+TIME_BITS+7)/8)*8-1:0] s_axis_tdata,

  // result stream
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // [DUTY_BITS-1:0] duty, then duty_write, is_ramping, is_latched,
  // timer_armed, timed_out; rest zero
  output logic [((DUTY_BITS+5+7)/8)*8-1:0] m_axis_tdata,

  // configuration writes
  input  logic                               cfg_wr_en,
  input  logic [mssr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mssr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int LB    = mssr_pkg::LEN_BITS;
  localparam int FB    = mssr_pkg::FUNC_BITS;
  localparam int OUT_W = ((DUTY_BITS+5+7)/8)*8;

  // configuration registers
  logic [DUTY_BITS-1:0] start_duty;
  logic [DUTY_BITS-1:0] end_duty;
  logic [LB-1:0]        ramp_length_ms;
  logic [LB-1:0]        idle_limit_ticks;

  // controller state
  logic                 ramp_active, ramp_active_next;
  logic                 held_at_max, held_at_max_next;
  logic [TIME_BITS-1:0] ramp_begin_ms, ramp_begin_ms_next;
  logic [LB-1:0]        idle_count, idle_count_next;
  logic                 watchdog_on, watchdog_on_next;

  // result register
  logic [DUTY_BITS-1:0] res_duty, res_duty_next;
  logic                 res_write, res_write_next;
  logic                 res_expired, res_expired_next;

  mssr_pkg::ctrl_state_t state, state_next;

  logic                 accept;
  logic [FB-1:0]        in_func;
  logic [TIME_BITS-1:0] in_now;
  logic [TIME_BITS-1:0] elapsed;
  logic                 ramp_done;
  logic                 rising;
  logic [DUTY_BITS-1:0] span;
  logic                 calc_go;
  logic                 arith_done;
  logic [DUTY_BITS-1:0] arith_quot;

  assign accept  = s_axis_tvalid & s_axis_tready;
  assign in_func = s_axis_tdata[FB-1:0];
  assign in_now  = s_axis_tdata[TIME_BITS+FB-1:FB];

  // wrapping elapsed time; a zero length always counts as finished
  assign elapsed   = in_now - ramp_begin_ms;
  assign ramp_done = elapsed >= TIME_BITS'(ramp_length_ms);

  // ramp direction and magnitude of the duty swing
  assign rising = end_duty >= start_duty;
  assign span   = rising ? (end_duty - start_duty) : (start_duty - end_duty);

  // configuration port
  always_ff @(posedge clk) begin
    if (rst) begin
      start_duty       <= DUTY_BITS'(mssr_pkg::RST_START_DUTY);
      end_duty         <= DUTY_BITS'(mssr_pkg::RST_END_DUTY);
      ramp_length_ms   <= LB'(mssr_pkg::RST_RAMP_LEN);
      idle_limit_ticks <= LB'(mssr_pkg::RST_IDLE_LIMIT);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mssr_pkg::REG_START_DUTY: start_duty       <= cfg_data[DUTY_BITS-1:0];
        mssr_pkg::REG_END_DUTY:   end_duty         <= cfg_data[DUTY_BITS-1:0];
        mssr_pkg::REG_RAMP_LEN:   ramp_length_ms   <= cfg_data[LB-1:0];
        mssr_pkg::REG_IDLE_LIMIT: idle_limit_ticks <= cfg_data[LB-1:0];
        default: ;
      endcase
    end
  end

  // command decode: everything but the interpolated duty settles here
  always_comb begin
    ramp_active_next   = ramp_active;
    held_at_max_next   = held_at_max;
    ramp_begin_ms_next = ramp_begin_ms;
    idle_count_next    = idle_count;
    watchdog_on_next   = watchdog_on;
    res_duty_next      = '0;
    res_write_next     = 1'b0;
    res_expired_next   = 1'b0;
    calc_go            = 1'b0;
    case (in_func)
      mssr_pkg::FN_START: begin
        // ignored while ramping or latched
        if (!ramp_active && !held_at_max) begin
          ramp_begin_ms_next = in_now;
          ramp_active_next   = 1'b1;
          res_duty_next      = start_duty;
          res_write_next     = 1'b1;
        end
      end
      mssr_pkg::FN_UPDATE: begin
        if (ramp_active) begin
          res_write_next = 1'b1;
          if (ramp_done) begin
            res_duty_next    = end_duty;
            ramp_active_next = 1'b0;
            held_at_max_next = 1'b1;
          end else begin
            calc_go = 1'b1;  // duty filled in by the divide unit
          end
        end
      end
      mssr_pkg::FN_STOP: begin
        res_write_next   = 1'b1;
        ramp_active_next = 1'b0;
        held_at_max_next = 1'b0;
      end
      mssr_pkg::FN_CANCEL: begin
        ramp_active_next = 1'b0;
        held_at_max_next = 1'b0;
      end
      mssr_pkg::FN_REARM: begin
        watchdog_on_next = 1'b1;
        idle_count_next  = idle_limit_ticks;
      end
      mssr_pkg::FN_TICK: begin
        if (idle_count != '0) begin
          idle_count_next = idle_count - LB'(1);
        end else if (watchdog_on) begin
          // watchdog expiry forces the motors off
          watchdog_on_next = 1'b0;
          ramp_active_next = 1'b0;
          held_at_max_next = 1'b0;
          res_write_next   = 1'b1;
          res_expired_next = 1'b1;
        end
      end
      default: ;  // unused codes only report the flags
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_active   <= 1'b0;
      held_at_max   <= 1'b0;
      ramp_begin_ms <= '0;
      idle_count    <= '0;
      watchdog_on   <= 1'b0;
    end else if (accept) begin
      ramp_active   <= ramp_active_next;
      held_at_max   <= held_at_max_next;
      ramp_begin_ms <= ramp_begin_ms_next;
      idle_count    <= idle_count_next;
      watchdog_on   <= watchdog_on_next;
    end
  end

  // result register; interpolated duty lands when the divide finishes
  always_ff @(posedge clk) begin
    if (accept) begin
      res_duty    <= res_duty_next;
      res_write   <= res_write_next;
      res_expired <= res_expired_next;
    end else if (state == mssr_pkg::ST_CALC && arith_done) begin
      res_duty <= rising ? (start_duty + arith_quot) : (start_duty - arith_quot);
    end
  end

  // span * elapsed / length, serial
  mssr_arith #(
    .DUTY_BITS(DUTY_BITS)
  ) u_arith (
    .clk     (clk),
    .rst     (rst),
    .start   (accept & calc_go),
    .factor  (span),
    .elapsed (elapsed[LB-1:0]),
    .length  (ramp_length_ms),
    .done    (arith_done),
    .quot    (arith_quot)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mssr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      mssr_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = calc_go ? mssr_pkg::ST_CALC : mssr_pkg::ST_SEND;
        end
      end
      mssr_pkg::ST_CALC: begin
        if (arith_done) begin
          state_next = mssr_pkg::ST_SEND;
        end
      end
      mssr_pkg::ST_SEND: begin
        if (m_axis_tready) begin
          state_next = mssr_pkg::ST_IDLE;
        end
      end
      default: state_next = mssr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state)
      mssr_pkg::ST_IDLE: s_axis_tready = 1'b1;
      mssr_pkg::ST_SEND: m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  // flags reflect controller state after the command
  assign m_axis_tdata = OUT_W'({res_expired, watchdog_on, held_at_max, ramp_active,
                                res_write, res_duty});

endmodule

// File: tb/tb_motor_soft_start_ramp_with_timeout.sv
// Self-checking testbench for motor_soft_start_ramp_with_timeout: directed and random
// command streams with idling and backpressure, checked against an in-bench predictor.
// Depends on mssr_pkg and the RTL top level only.
module tb_motor_soft_start_ramp_with_timeout;

  localparam int DUTY_W = mssr_pkg::DUTY_BITS_DEF;
  localparam int TIME_W = mssr_pkg::TIME_BITS_DEF;
  localparam int FUNC_W = mssr_pkg::FUNC_BITS;
  localparam int S_W    = ((FUNC_W + TIME_W + 7) / 8) * 8;
  localparam int M_W    = ((DUTY_W + 5 + 7) / 8) * 8;

  // Codes the block has no command for; they only report the flags.
  localparam logic [FUNC_W-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE7 = 3'd7;

  // One result, packed the way m_axis_tdata carries it (duty in the low bits).
  typedef struct packed {
    logic              timed_out;
    logic              timer_armed;
    logic              is_latched;
    logic              is_ramping;
    logic              duty_write;
    logic [DUTY_W-1:0] duty;
  } motor_result_t;

  logic clk;
  logic rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [S_W-1:0]   s_axis_tdata;   // [2:0] func, [34:3] now_ms, rest zero
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [M_W-1:0]   m_axis_tdata;   // [7:0] duty, duty_write, is_ramping, is_latched,
                                    // timer_armed, timed_out, rest zero
  logic                               cfg_wr_en;
  logic [mssr_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [mssr_pkg::CFG_DATA_BITS-1:0] cfg_data;

  motor_soft_start_ramp_with_timeout DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor: private copy of the controller state and its registers.
  // ---------------------------------------------------------------------------
  logic [DUTY_W-1:0] cfg_start;
  logic [DUTY_W-1:0] cfg_end;
  logic [15:0]       cfg_len;
  logic [15:0]       cfg_idle;

  logic              ramp_on;      // ramp in progress
  logic              at_end;       // ramp finished, duty held at end value
  logic [TIME_W-1:0] ramp_t0;      // timestamp of the start command
  logic [15:0]       idle_left;    // watchdog ticks still to go
  logic              wd_on;        // watchdog armed

  motor_result_t duty_expected_q[$];   // expected results, oldest first

  int items_sent;
  int err_count;
  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_req;    // long receiver hold requested by a test
  int recv_hold_left;

  function automatic motor_result_t predict_ramp_cmd(logic [FUNC_W-1:0] fn,
                                                     logic [TIME_W-1:0] now_ms);
    motor_result_t     r;
    logic [TIME_W-1:0] elapsed;
    logic [DUTY_W-1:0] span;
    logic [47:0]       quot;
    r = '0;
    case (fn)
      mssr_pkg::FN_START: begin
        // ignored while ramping or latched
        if (!ramp_on && !at_end) begin
          ramp_t0      = now_ms;
          ramp_on      = 1'b1;
          r.duty       = cfg_start;
          r.duty_write = 1'b1;
        end
      end
      mssr_pkg::FN_UPDATE: begin
        if (ramp_on) begin
          elapsed = now_ms - ramp_t0;   // wraps with the timestamp
          if (elapsed >= TIME_W'(cfg_len)) begin
            // covers a zero length too: latch without dividing
            r.duty  = cfg_end;
            ramp_on = 1'b0;
            at_end  = 1'b1;
          end else begin
            span = (cfg_end >= cfg_start) ? cfg_end - cfg_start : cfg_start - cfg_end;
            quot = (48'(span) * 48'(elapsed)) / 48'(cfg_len);
            r.duty = (cfg_end >= cfg_start) ? cfg_start + quot[DUTY_W-1:0]
                                            : cfg_start - quot[DUTY_W-1:0];
          end
          r.duty_write = 1'b1;
        end
      end
      mssr_pkg::FN_STOP: begin
        r.duty_write = 1'b1;
        ramp_on      = 1'b0;
        at_end       = 1'b0;
      end
      mssr_pkg::FN_CANCEL: begin
        ramp_on = 1'b0;
        at_end  = 1'b0;
      end
      mssr_pkg::FN_REARM: begin
        wd_on     = 1'b1;
        idle_left = cfg_idle;
      end
      mssr_pkg::FN_TICK: begin
        if (idle_left != 16'd0) begin
          idle_left = idle_left - 16'd1;
        end else if (wd_on) begin
          // watchdog expiry forces the motors off
          wd_on        = 1'b0;
          ramp_on      = 1'b0;
          at_end       = 1'b0;
          r.duty_write = 1'b1;
          r.timed_out  = 1'b1;
        end
      end
      default: ;
    endcase
    r.is_ramping  = ramp_on;
    r.is_latched  = at_end;
    r.timer_armed = wd_on;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus primitives. All of them are entered and left at a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(input logic [FUNC_W-1:0] fn, input logic [TIME_W-1:0] now_ms);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_W'({now_ms, fn});
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    duty_expected_q.push_back(predict_ramp_cmd(fn, now_ms));
    items_sent++;
  endtask

  // Sender stops offering and waits for every outstanding transaction to come back.
  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (duty_expected_q.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  // Writes all four registers back to back; only called while the block is idle.
  task automatic write_regs(input logic [DUTY_W-1:0] st, input logic [DUTY_W-1:0] en,
                            input logic [15:0] len, input logic [15:0] idle);
    cfg_wr_en <= 1'b1;
    cfg_index <= mssr_pkg::REG_START_DUTY;
    cfg_data  <= {8'($urandom), st};    // upper byte is don't-care for duty regs
    @(posedge clk);
    cfg_index <= mssr_pkg::REG_END_DUTY;
    cfg_data  <= {8'($urandom), en};
    @(posedge clk);
    cfg_index <= mssr_pkg::REG_RAMP_LEN;
    cfg_data  <= len;
    @(posedge clk);
    cfg_index <= mssr_pkg::REG_IDLE_LIMIT;
    cfg_data  <= idle;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_start = st;
    cfg_end   = en;
    cfg_len   = len;
    cfg_idle  = idle;
  endtask

  function automatic logic [DUTY_W-1:0] pick_duty();
    int p;
    p = $urandom_range(99);
    if (p < 15) return '0;
    if (p < 30) return '1;
    return DUTY_W'($urandom);
  endfunction

  function automatic logic [FUNC_W-1:0] FN_FUNC_NOISE();
    return FUNC_W'($urandom_range(0, 7));
  endfunction

  task automatic randomize_regs();
    logic [15:0] len;
    logic [15:0] idle;
    int p;
    p = $urandom_range(99);
    if (p < 50)      len = 16'($urandom_range(1, 64));
    else if (p < 80) len = 16'($urandom_range(1, 4000));
    else if (p < 90) len = 16'hFFFF;
    else             len = 16'($urandom_range(1, 65535));
    p = $urandom_range(99);
    if (p < 60)      idle = 16'($urandom_range(0, 6));
    else if (p < 85) idle = 16'($urandom_range(7, 100));
    else if (p < 95) idle = 16'($urandom);
    else             idle = 16'hFFFF;
    write_regs(pick_duty(), pick_duty(), len, idle);
  endtask

  // Start, a handful of updates walking forward in time, maybe a stop or cancel.
  task automatic ramp_burst();
    logic [TIME_W-1:0] t;
    int n_upd;
    int step_max;
    int p;
    p = $urandom_range(99);
    if (p < 25)      send_cmd(mssr_pkg::FN_STOP, $urandom);
    else if (p < 40) send_cmd(mssr_pkg::FN_CANCEL, $urandom);
    t = $urandom;
    send_cmd(mssr_pkg::FN_START, t);
    n_upd    = $urandom_range(1, 8);
    step_max = int'(cfg_len) / 3 + 1;
    for (int k = 0; k < n_upd; k++) begin
      p = $urandom_range(99);
      if (p < 8)       t = $urandom;                       // jump anywhere, even backwards
      else if (p < 14) send_cmd(mssr_pkg::FN_TICK, $urandom);
      else if (p < 18) send_cmd(mssr_pkg::FN_START, t);    // start while busy
      else             t = t + TIME_W'($urandom_range(0, step_max));
      send_cmd(mssr_pkg::FN_UPDATE, t);
    end
    p = $urandom_range(99);
    if (p < 30)      send_cmd(mssr_pkg::FN_STOP, $urandom);
    else if (p < 45) send_cmd(mssr_pkg::FN_CANCEL, $urandom);
  endtask

  // Rearm and tick down, with the odd ramp command mixed in.
  task automatic watchdog_burst();
    int n_ticks;
    int p;
    if ($urandom_range(99) < 70) send_cmd(mssr_pkg::FN_REARM, $urandom);
    n_ticks = $urandom_range(1, 9);
    for (int k = 0; k < n_ticks; k++) begin
      p = $urandom_range(99);
      if (p < 6)       send_cmd(mssr_pkg::FN_START, $urandom);
      else if (p < 12) send_cmd(mssr_pkg::FN_UPDATE, $urandom);
      else             send_cmd(mssr_pkg::FN_TICK, $urandom);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    // Reset registers: rising ramp 100 -> 255 over 2000 ms, 30 idle ticks.
    send_cmd(mssr_pkg::FN_UPDATE, 32'd0);              // update with no ramp
    send_cmd(mssr_pkg::FN_TICK, 32'd0);                // tick, count zero, watchdog off
    send_cmd(mssr_pkg::FN_START, 32'hFFFF_FF00);       // ramp begins just before the wrap
    send_cmd(mssr_pkg::FN_START, 32'd7);               // start while ramping: ignored
    send_cmd(mssr_pkg::FN_UPDATE, 32'h0000_0100);      // elapsed wraps past zero
    send_cmd(mssr_pkg::FN_UPDATE, 32'h0000_06CF);      // one ms short of the end
    send_cmd(mssr_pkg::FN_UPDATE, 32'h0000_06D0);      // reaches the length: latch
    send_cmd(mssr_pkg::FN_START, 32'hFFFF_FFFF);       // start while latched: ignored
    send_cmd(mssr_pkg::FN_UPDATE, 32'h0000_0800);      // update while latched: nothing
    send_cmd(mssr_pkg::FN_CANCEL, 32'd0);
    send_cmd(FN_SPARE6, 32'hFFFF_FFFF);
    send_cmd(FN_SPARE7, 32'h5555_AAAA);
    send_cmd(mssr_pkg::FN_STOP, 32'hFFFF_FFFF);
    wait_results_done();

    // Falling ramp at full swing and maximum length; watchdog with no slack.
    write_regs('1, '0, 16'hFFFF, 16'd0);
    send_cmd(mssr_pkg::FN_START, 32'd0);
    send_cmd(mssr_pkg::FN_UPDATE, 32'd65534);
    send_cmd(mssr_pkg::FN_UPDATE, 32'd32767);
    send_cmd(mssr_pkg::FN_REARM, 32'd0);
    send_cmd(mssr_pkg::FN_TICK, 32'd1);                // expires at once, ramp cleared
    send_cmd(mssr_pkg::FN_TICK, 32'd2);                // watchdog already off
    wait_results_done();

    // Zero ramp length latches on the first update; count down from two.
    write_regs('0, '1, 16'd0, 16'd2);
    send_cmd(mssr_pkg::FN_START, 32'd5);
    send_cmd(mssr_pkg::FN_UPDATE, 32'd5);
    send_cmd(mssr_pkg::FN_REARM, 32'd9);
    send_cmd(mssr_pkg::FN_TICK, 32'd10);               // count nonzero: just decrements
    send_cmd(mssr_pkg::FN_TICK, 32'd11);
    send_cmd(mssr_pkg::FN_TICK, 32'd12);               // expiry clears the latch
    wait_results_done();
  endtask

  task automatic test_random_traffic(input int n_items);
    int target;
    int next_cfg;
    int p;
    target   = items_sent + n_items;
    next_cfg = items_sent;
    while (items_sent < target) begin
      if (items_sent >= next_cfg) begin
        wait_results_done();
        randomize_regs();
        next_cfg = items_sent + 50;
      end
      p = $urandom_range(99);
      if (p < 55)      ramp_burst();
      else if (p < 80) watchdog_burst();
      else             send_cmd(FN_FUNC_NOISE(), $urandom);
    end
  endtask

  // Receiver holds off for a long stretch while commands keep coming, so the
  // block fills up and drops s_axis_tready; then the sender waits for all results.
  task automatic test_output_backpressure();
    logic [TIME_W-1:0] t;
    wait_results_done();
    write_regs(8'd20, 8'd220, 16'd400, 16'd3);
    recv_hold_req = 300;
    t = $urandom;
    send_cmd(mssr_pkg::FN_START, t);
    for (int k = 0; k < 10; k++) begin
      t = t + TIME_W'($urandom_range(0, 60));
      send_cmd(mssr_pkg::FN_UPDATE, t);
    end
    send_cmd(mssr_pkg::FN_REARM, t);
    wait_results_done();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random tready, long hold on request, compare each transaction.
  // ---------------------------------------------------------------------------
  task automatic check_result();
    motor_result_t got;
    motor_result_t want;
    got = motor_result_t'(m_axis_tdata[DUTY_W+4:0]);
    if (duty_expected_q.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("ERROR: result with nothing expected: duty=%0d flags=%b",
                 got.duty, got[DUTY_W+4:DUTY_W]);
    end else begin
      want = duty_expected_q.pop_front();
      if (got.duty !== want.duty || got.duty_write !== want.duty_write ||
          got.is_ramping !== want.is_ramping || got.is_latched !== want.is_latched ||
          got.timer_armed !== want.timer_armed || got.timed_out !== want.timed_out) begin
        err_count++;
        if (err_count <= 10) begin
          $display("ERROR: mismatch: exp duty=%0d wr=%b ramp=%b latch=%b arm=%b to=%b",
                   want.duty, want.duty_write, want.is_ramping, want.is_latched,
                   want.timer_armed, want.timed_out);
          $display("                 act duty=%0d wr=%b ramp=%b latch=%b arm=%b to=%b",
                   got.duty, got.duty_write, got.is_ramping, got.is_latched,
                   got.timer_armed, got.timed_out);
        end
      end
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (recv_hold_left == 0 && recv_hold_req > 0) begin
        recv_hold_left = recv_hold_req;
        recv_hold_req  = 0;
      end
      if (recv_hold_left > 0) begin
        recv_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_index      = mssr_pkg::REG_START_DUTY;
    cfg_data       = '0;
    items_sent     = 0;
    err_count      = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    recv_hold_req  = 0;
    recv_hold_left = 0;

    // predictor starts from the reset state
    cfg_start = DUTY_W'(mssr_pkg::RST_START_DUTY);
    cfg_end   = DUTY_W'(mssr_pkg::RST_END_DUTY);
    cfg_len   = 16'(mssr_pkg::RST_RAMP_LEN);
    cfg_idle  = 16'(mssr_pkg::RST_IDLE_LIMIT);
    ramp_on   = 1'b0;
    at_end    = 1'b0;
    ramp_t0   = '0;
    idle_left = '0;
    wd_on     = 1'b0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 63;
    test_directed();
    test_random_traffic(200);

    send_idle_pct = 63;
    recv_idle_pct = 29;
    test_output_backpressure();
    test_random_traffic(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(200);

    // let any stray transaction show up before judging
    wait_results_done();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
